/* sv/ile_pkg.sv */
// Shared types, codes and default sizes for the indexed list engine.
package ile_pkg;

  // Default sizes of the list store.
  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed widths of the transaction fields.
  localparam int COMMAND_WIDTH   = 4;
  localparam int POSITION_WIDTH  = 6;
  localparam int WORD_WIDTH      = 32;
  localparam int STATUS_WIDTH    = 3;
  localparam int COUNT_OUT_WIDTH = 7;

  // Command codes.
  typedef enum logic [COMMAND_WIDTH-1:0] {
    CMD_INSERT_AT  = 4'd0,
    CMD_PUSH_FRONT = 4'd1,
    CMD_PUSH_BACK  = 4'd2,
    CMD_REMOVE_AT  = 4'd3,
    CMD_POP_FRONT  = 4'd4,
    CMD_POP_BACK   = 4'd5,
    CMD_READ_AT    = 4'd6,
    CMD_READ_FRONT = 4'd7,
    CMD_READ_BACK  = 4'd8,
    CMD_FIND       = 4'd9
  } command_t;

  // Result status codes.
  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // What every cell does with its word on a step of the row.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  // Control broadcast along the row of cells.
  typedef struct packed {
    cell_op_t op;
    logic     capture;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_EXEC = 2'd1,
    FSM_DONE = 2'd2
  } fsm_t;

endpackage

/* sv/ile_cell.sv */
// One list cell: holds a word, shifts with its neighbours and flags selection and matches.
module ile_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int PW         = 6,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  ile_pkg::cell_ctrl_t   ctrl,
  input  logic [PW-1:0]         target,
  input  logic [PW-1:0]         count,
  input  logic [DATA_WIDTH-1:0] new_word,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  input  logic [DATA_WIDTH-1:0] find_word,
  output logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] sel_word,
  output logic                  hit
);
  import ile_pkg::*;

  localparam logic [PW-1:0] IDX = PW'(INDEX);

  // Shift the stored word to make room or to close a gap, or take the new word at the target.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (IDX > target) begin
          word <= left_word;
        end else if (IDX == target) begin
          word <= new_word;
        end
      end
      CELL_REMOVE: begin
        if (IDX >= target) begin
          word <= right_word;
        end
      end
      default: begin
      end
    endcase
  end

  // Capture the old word if selected, and whether it is a live entry that matches the search word.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      sel_word <= (IDX == target) ? word : '0;
      hit      <= (word == find_word) && (IDX < count);
    end
  end

endmodule

/* sv/ile_reduce.sv */
// Combines the cell flags: first match position and the selected word.
module ile_reduce #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 6
) (
  input  logic [DEPTH-1:0]      hit,
  input  logic [DATA_WIDTH-1:0] sel_word [DEPTH],
  output logic                  any_hit,
  output logic [IW-1:0]         first_pos,
  output logic [DATA_WIDTH-1:0] read_word
);
  import ile_pkg::*;

  logic [DEPTH-1:0] first_hot;

  // Isolate the lowest set hit bit with one wide add.
  assign first_hot = hit & (~hit + DEPTH'(1));
  assign any_hit   = |hit;

  // One-hot to binary, and an OR of the masked words.
  always_comb begin
    first_pos = '0;
    read_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_hot[i]) begin
        first_pos = first_pos | IW'(i);
      end
      read_word = read_word | sel_word[i];
    end
  end

endmodule

/* sv/indexed_list_engine.sv */
// Top level of the indexed list engine: command decode, sequencer, row of cells, result register.
//
// An ordered list of up to DEPTH words, front at position 0. A command
// transaction (command, position_in, word_in) is taken on command_valid and
// command_ready; one result transaction (status, word_out, found_position,
// entry_count) leaves on result_valid and result_ready for every command.
// Each cell holds one entry and shifts to or from its neighbour, so an insert
// or removal at any position takes one step of the row; a read or find makes
// every cell compare locally, and the flags are combined in the next cycle.
// A command passes decode, one cell step, then combine, and the result is
// loaded at the end of combine; no command is taken before it is loaded.
// command_ready is high only while the sequencer is idle, and a new command
// may be taken while the previous result still waits in the output register.
// If the receiver stalls, the combine step holds until the output register
// is free, and no further command is taken meanwhile.
// Synchronous reset empties the list (count zero) and drops any result;
// stored words need no clearing, as only entries below the count are read.
module indexed_list_engine #(
  parameter int DEPTH      = ile_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      command_valid,
  output logic                                      command_ready,
  input  logic        [ile_pkg::COMMAND_WIDTH-1:0]   command,
  input  logic        [ile_pkg::POSITION_WIDTH-1:0]  position_in,
  input  logic signed [ile_pkg::WORD_WIDTH-1:0]      word_in,
  output logic                                      result_valid,
  input  logic                                      result_ready,
  output logic        [ile_pkg::STATUS_WIDTH-1:0]    status,
  output logic signed [ile_pkg::WORD_WIDTH-1:0]      word_out,
  output logic        [ile_pkg::POSITION_WIDTH-1:0]  found_position,
  output logic        [ile_pkg::COUNT_OUT_WIDTH-1:0] entry_count
);
  import ile_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POSITION_WIDTH) ? CW : POSITION_WIDTH;
  localparam int IW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  fsm_t                  state, state_next;
  logic [CW-1:0]         count;
  logic [PW-1:0]         count_pw;
  logic [PW-1:0]         pos_pw;
  command_t              cmd;
  logic [DATA_WIDTH+WORD_WIDTH-1:0] word_in_ext;
  logic [DATA_WIDTH-1:0] word_dw;

  // Decoded command, held for the cell step.
  status_t               dec_status;
  cell_op_t              dec_op;
  logic                  dec_capture;
  logic [PW-1:0]         dec_target;
  logic                  dec_find;
  logic                  dec_want_word;

  status_t               status_q;
  cell_op_t              op_q;
  logic                  capture_q;
  logic [PW-1:0]         target_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic                  find_q;
  logic                  want_word_q;

  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  logic [DATA_WIDTH-1:0] cell_sel  [DEPTH];
  logic [DEPTH-1:0]      cell_hit;

  logic                  any_hit;
  logic [IW-1:0]         first_pos;
  logic [DATA_WIDTH-1:0] read_word;
  logic                  take;
  logic                  load;

  logic [DATA_WIDTH+WORD_WIDTH-1:0]      read_ext;
  logic [IW+POSITION_WIDTH-1:0]          pos_ext;
  logic [CW+COUNT_OUT_WIDTH-1:0]         count_ext;

  assign cmd         = command_t'(command);
  assign count_pw    = PW'(count);
  assign pos_pw      = PW'(position_in);
  assign word_in_ext = {{DATA_WIDTH{1'b0}}, word_in};
  assign word_dw     = word_in_ext[DATA_WIDTH-1:0];

  // Command decode against the current count.
  always_comb begin
    dec_status    = ST_OK;
    dec_op        = CELL_HOLD;
    dec_capture   = 1'b0;
    dec_target    = '0;
    dec_find      = 1'b0;
    dec_want_word = 1'b0;
    unique case (cmd)
      CMD_INSERT_AT, CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (cmd == CMD_INSERT_AT) begin
          dec_target = pos_pw;
        end else if (cmd == CMD_PUSH_FRONT) begin
          dec_target = '0;
        end else begin
          dec_target = count_pw;
        end
        if (count_pw >= DEPTH_P) begin
          dec_status = ST_FULL;
        end else if (dec_target > count_pw) begin
          dec_status = ST_RANGE;
        end else begin
          dec_op = CELL_INSERT;
        end
      end
      CMD_REMOVE_AT, CMD_POP_FRONT, CMD_POP_BACK,
      CMD_READ_AT, CMD_READ_FRONT, CMD_READ_BACK: begin
        if (cmd == CMD_REMOVE_AT || cmd == CMD_READ_AT) begin
          dec_target = pos_pw;
        end else if (cmd == CMD_POP_FRONT || cmd == CMD_READ_FRONT) begin
          dec_target = '0;
        end else begin
          dec_target = count_pw - PW'(1);
        end
        if (count_pw == '0) begin
          dec_status = ST_EMPTY;
        end else if (dec_target >= count_pw) begin
          dec_status = ST_RANGE;
        end else begin
          dec_capture   = 1'b1;
          dec_want_word = 1'b1;
          if (cmd == CMD_REMOVE_AT || cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) begin
            dec_op = CELL_REMOVE;
          end
        end
      end
      CMD_FIND: begin
        if (count_pw == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_capture = 1'b1;
          dec_find    = 1'b1;
        end
      end
      default: begin
        dec_status = ST_RANGE;
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and handshake.
  always_comb begin
    state_next    = state;
    command_ready = 1'b0;
    load          = 1'b0;
    ctrl          = '{op: CELL_HOLD, capture: 1'b0};
    unique case (state)
      FSM_IDLE: begin
        command_ready = 1'b1;
        if (command_valid) begin
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        ctrl       = '{op: op_q, capture: capture_q};
        state_next = FSM_DONE;
      end
      FSM_DONE: begin
        if (!result_valid || result_ready) begin
          load       = 1'b1;
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  assign take = command_valid && command_ready;

  // Hold the decoded transaction for the cell step.
  always_ff @(posedge clk) begin
    if (take) begin
      status_q    <= dec_status;
      op_q        <= dec_op;
      capture_q   <= dec_capture;
      target_q    <= dec_target;
      word_q      <= word_dw;
      find_q      <= dec_find;
      want_word_q <= dec_want_word;
    end
  end

  // Entry count follows the cell step.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == FSM_EXEC) begin
      if (op_q == CELL_INSERT) begin
        count <= count + CW'(1);
      end else if (op_q == CELL_REMOVE) begin
        count <= count - CW'(1);
      end
    end
  end

  // The row of cells; the ends take their own word or the new word.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_word;
    logic [DATA_WIDTH-1:0] right_word;
    if (i == 0) begin : g_first
      assign left_word = word_q;
    end else begin : g_inner_left
      assign left_word = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_word = cell_word[i];
    end else begin : g_inner_right
      assign right_word = cell_word[i+1];
    end
    ile_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .PW        (PW),
      .INDEX     (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .target    (target_q),
      .count     (count_pw),
      .new_word  (word_q),
      .left_word (left_word),
      .right_word(right_word),
      .find_word (word_q),
      .word      (cell_word[i]),
      .sel_word  (cell_sel[i]),
      .hit       (cell_hit[i])
    );
  end

  ile_reduce #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH),
    .IW        (IW)
  ) u_reduce (
    .hit      (cell_hit),
    .sel_word (cell_sel),
    .any_hit  (any_hit),
    .first_pos(first_pos),
    .read_word(read_word)
  );

  assign read_ext  = {{WORD_WIDTH{1'b0}}, read_word};
  assign pos_ext   = {{POSITION_WIDTH{1'b0}}, first_pos};
  assign count_ext = {{COUNT_OUT_WIDTH{1'b0}}, count};

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      entry_count    <= count_ext[COUNT_OUT_WIDTH-1:0];
      word_out       <= want_word_q ? read_ext[WORD_WIDTH-1:0] : '0;
      found_position <= (find_q && any_hit) ? pos_ext[POSITION_WIDTH-1:0] : '0;
      if (find_q) begin
        status <= any_hit ? ST_OK : ST_NOTFOUND;
      end else begin
        status <= status_q;
      end
    end
  end

endmodule

/* tb/sv/indexed_list_engine_tb.sv */
// Self-checking testbench for the indexed list engine, with its own list predictor.
module indexed_list_engine_tb;
  import ile_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = ile_pkg::DEPTH_DEFAULT;
  localparam logic [COMMAND_WIDTH-1:0] CMD_UNDEFINED_FIRST = 4'd10;
  localparam logic [COMMAND_WIDTH-1:0] CMD_UNDEFINED_LAST  = 4'd15;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam int DRAIN_CYCLES = 8;

  // One result transaction as the predictor expects it.
  typedef struct {
    status_t                    status;
    logic signed [WORD_WIDTH-1:0] word;
    logic [POSITION_WIDTH-1:0]  found;
    logic [COUNT_OUT_WIDTH-1:0] count;
  } list_result_t;

  logic                              clk;
  logic                              rst;
  logic                              command_valid;
  logic                              command_ready;
  logic        [COMMAND_WIDTH-1:0]   command;
  logic        [POSITION_WIDTH-1:0]  position_in;
  logic signed [WORD_WIDTH-1:0]      word_in;
  logic                              result_valid;
  logic                              result_ready;
  logic        [STATUS_WIDTH-1:0]    status;
  logic signed [WORD_WIDTH-1:0]      word_out;
  logic        [POSITION_WIDTH-1:0]  found_position;
  logic        [COUNT_OUT_WIDTH-1:0] entry_count;

  // Predicted list contents and outstanding results.
  logic signed [WORD_WIDTH-1:0] list_words [LIST_DEPTH];
  int                           list_count;
  list_result_t                 expected_results [$];

  int error_count;
  int idle_cycles;
  int result_hold_cycles;
  bit gaps_on;

  indexed_list_engine DUT (
    .clk            (clk),
    .rst            (rst),
    .command_valid  (command_valid),
    .command_ready  (command_ready),
    .command        (command),
    .position_in    (position_in),
    .word_in        (word_in),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .status         (status),
    .word_out       (word_out),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

  // Free-running clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one command to the predicted list and return the result it gives.
  function automatic list_result_t apply_command(input logic [COMMAND_WIDTH-1:0] cmd,
                                                 input logic [POSITION_WIDTH-1:0] pos,
                                                 input logic signed [WORD_WIDTH-1:0] word);
    list_result_t r;
    int at;
    int i;
    r.status = ST_OK;
    r.word   = '0;
    r.found  = '0;
    case (cmd)
      CMD_INSERT_AT, CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (list_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          at = (cmd == CMD_INSERT_AT) ? int'(pos) : (cmd == CMD_PUSH_FRONT) ? 0 : list_count;
          if (at > list_count) begin
            r.status = ST_RANGE;
          end else begin
            for (i = list_count; i > at; i--) list_words[i] = list_words[i-1];
            list_words[at] = word;
            list_count++;
          end
        end
      end
      CMD_REMOVE_AT, CMD_POP_FRONT, CMD_POP_BACK,
      CMD_READ_AT, CMD_READ_FRONT, CMD_READ_BACK: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (cmd == CMD_REMOVE_AT || cmd == CMD_READ_AT) at = int'(pos);
          else if (cmd == CMD_POP_FRONT || cmd == CMD_READ_FRONT) at = 0;
          else at = list_count - 1;
          if (at >= list_count) begin
            r.status = ST_RANGE;
          end else begin
            r.word = list_words[at];
            if (cmd == CMD_REMOVE_AT || cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) begin
              for (i = at; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
              list_count--;
            end
          end
        end
      end
      CMD_FIND: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < list_count; i++) begin
            if (list_words[i] == word) begin
              r.status = ST_OK;
              r.found  = i[POSITION_WIDTH-1:0];
              break;
            end
          end
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = list_count[COUNT_OUT_WIDTH-1:0];
    return r;
  endfunction

  // Offer one command transaction, after a random gap when gaps are on, and wait until it is taken.
  task automatic send_command(input logic [COMMAND_WIDTH-1:0] cmd,
                              input logic [POSITION_WIDTH-1:0] pos,
                              input logic signed [WORD_WIDTH-1:0] word);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      command_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command       = cmd;
    position_in   = pos;
    word_in       = word;
    command_valid = 1'b1;
    do @(posedge clk); while (!command_ready);
    expected_results.push_back(apply_command(cmd, pos, word));
    @(negedge clk);
  endtask

  // Stop offering commands until every outstanding result has been returned.
  task automatic wait_for_results;
    command_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Word values that favour extremes and small repeated values, so finds hit.
  function automatic logic signed [WORD_WIDTH-1:0] pick_word;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 7);
      3:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  // A valid list position most of the time, otherwise anywhere in the field.
  function automatic logic [POSITION_WIDTH-1:0] pick_position(input int limit);
    if (limit >= 0 && $urandom_range(0, 4) != 0) begin
      return POSITION_WIDTH'($urandom_range(0, limit));
    end
    return POSITION_WIDTH'($urandom_range(0, (1 << POSITION_WIDTH) - 1));
  endfunction

  // One random command, leaning towards inserts while growing and removals while shrinking.
  task automatic send_random_command(input bit growing);
    int pick;
    logic [COMMAND_WIDTH-1:0] cmd;
    logic signed [WORD_WIDTH-1:0] word;
    logic [POSITION_WIDTH-1:0] pos;
    pick = $urandom_range(0, 99);
    word = pick_word();
    if (pick < (growing ? 60 : 15)) begin
      cmd = CMD_INSERT_AT + COMMAND_WIDTH'($urandom_range(0, 2));
      pos = pick_position(list_count);
    end else if (pick < (growing ? 75 : 60)) begin
      cmd = CMD_REMOVE_AT + COMMAND_WIDTH'($urandom_range(0, 2));
      pos = pick_position(list_count - 1);
    end else if (pick < 95) begin
      cmd = CMD_READ_AT + COMMAND_WIDTH'($urandom_range(0, 3));
      pos = pick_position(list_count - 1);
      if (cmd == CMD_FIND && list_count > 0 && $urandom_range(0, 4) != 0)
        word = list_words[$urandom_range(0, list_count - 1)];
    end else begin
      cmd = COMMAND_WIDTH'($urandom_range(CMD_UNDEFINED_FIRST, CMD_UNDEFINED_LAST));
      pos = POSITION_WIDTH'($urandom);
    end
    send_command(cmd, pos, word);
  endtask

  // Every removal, read and find on an empty list, and an insert beyond the end.
  task automatic test_empty_list;
    send_command(CMD_POP_FRONT, 6'd0, 32'sd0);
    send_command(CMD_POP_BACK, 6'd0, 32'sd0);
    send_command(CMD_REMOVE_AT, 6'd0, 32'sd0);
    send_command(CMD_READ_FRONT, 6'd0, 32'sd0);
    send_command(CMD_READ_BACK, 6'd0, 32'sd0);
    send_command(CMD_READ_AT, 6'd63, 32'sd0);
    send_command(CMD_FIND, 6'd0, 32'sd0);
    send_command(CMD_INSERT_AT, 6'd1, 32'sd5);
  endtask

  // Every command at least once on a short list, plus an undefined code, with word extremes and position edges.
  task automatic test_basic_commands;
    send_command(CMD_INSERT_AT, 6'd0, 32'sh7fffffff);
    send_command(CMD_PUSH_FRONT, 6'd0, 32'sh80000000);
    send_command(CMD_PUSH_BACK, 6'd0, -32'sd1);
    send_command(CMD_INSERT_AT, 6'd3, 32'sd0);
    send_command(CMD_INSERT_AT, 6'd1, 32'sh55555555);
    send_command(CMD_INSERT_AT, 6'd6, 32'sd9);
    send_command(CMD_READ_AT, 6'd4, 32'sd0);
    send_command(CMD_READ_AT, 6'd5, 32'sd0);
    send_command(CMD_READ_FRONT, 6'd0, 32'sd0);
    send_command(CMD_READ_BACK, 6'd63, 32'sd0);
    send_command(CMD_PUSH_BACK, 6'd0, 32'sh7fffffff);
    send_command(CMD_FIND, 6'd0, 32'sh7fffffff);
    send_command(CMD_FIND, 6'd0, 32'sh12345678);
    send_command(CMD_UNDEFINED_LAST, 6'd63, -32'sd1);
    send_command(CMD_REMOVE_AT, 6'd2, 32'sd0);
    send_command(CMD_REMOVE_AT, 6'd5, 32'sd0);
    send_command(CMD_POP_FRONT, 6'd0, 32'sd0);
    send_command(CMD_POP_BACK, 6'd0, 32'sd0);
  endtask

  // Fill the list to capacity, try every insert while full, then empty it again.
  task automatic test_full_list;
    logic [COMMAND_WIDTH-1:0] cmd;
    while (list_count < LIST_DEPTH) begin
      cmd = CMD_INSERT_AT + COMMAND_WIDTH'($urandom_range(0, 2));
      send_command(cmd, POSITION_WIDTH'($urandom_range(0, list_count)), pick_word());
    end
    send_command(CMD_PUSH_FRONT, 6'd0, 32'sd1);
    send_command(CMD_PUSH_BACK, 6'd0, 32'sd1);
    send_command(CMD_INSERT_AT, 6'd0, 32'sd1);
    send_command(CMD_INSERT_AT, 6'd63, 32'sd1);
    send_command(CMD_READ_AT, 6'd63, 32'sd0);
    send_command(CMD_READ_BACK, 6'd0, 32'sd0);
    send_command(CMD_FIND, 6'd0, list_words[LIST_DEPTH-1]);
    send_command(CMD_REMOVE_AT, 6'd63, 32'sd0);
    send_command(CMD_INSERT_AT, 6'd63, 32'sh7fffffff);
    send_command(CMD_FIND, 6'd0, 32'sh7fffffff);
    while (list_count > 0) begin
      cmd = CMD_REMOVE_AT + COMMAND_WIDTH'($urandom_range(0, 2));
      send_command(cmd, POSITION_WIDTH'($urandom_range(0, list_count - 1)), 32'sd0);
    end
    send_command(CMD_POP_BACK, 6'd0, 32'sd0);
  endtask

  // The receiver holds off for a long stretch while commands keep coming.
  task automatic test_back_pressure;
    gaps_on = 1'b0;
    result_hold_cycles = HOLD_OFF_CYCLES;
    repeat (20) send_random_command(1'b1);
    wait_for_results();
    gaps_on = 1'b1;
  endtask

  // Random traffic that sweeps the list between empty and full.
  task automatic test_random_traffic(input int n_items, input bit with_gaps);
    bit growing;
    growing = 1'b1;
    gaps_on = with_gaps;
    repeat (n_items) begin
      if (list_count >= LIST_DEPTH) growing = 1'b0;
      else if (list_count == 0) growing = 1'b1;
      send_random_command(growing);
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: random stalls per transaction, and a long hold-off on request.
  initial begin : result_receiver
    int stall;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (result_hold_cycles > 0) begin
        result_ready = 1'b0;
        repeat (result_hold_cycles) @(negedge clk);
        result_hold_cycles = 0;
      end
      stall = gaps_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        result_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready = 1'b1;
      do @(posedge clk); while (rst || !result_valid);
    end
  end

  // Compare every returned result with the oldest outstanding prediction.
  always @(posedge clk) begin
    list_result_t r;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing outstanding");
        error_count++;
      end else begin
        r = expected_results.pop_front();
        if (status !== r.status) begin
          $error("status: expected %0d, got %0d", r.status, status);
          error_count++;
        end
        if (word_out !== r.word) begin
          $error("word_out: expected %0d, got %0d", r.word, word_out);
          error_count++;
        end
        if (found_position !== r.found) begin
          $error("found_position: expected %0d, got %0d", r.found, found_position);
          error_count++;
        end
        if (entry_count !== r.count) begin
          $error("entry_count: expected %0d, got %0d", r.count, entry_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (command_valid && command_ready) || (result_valid && result_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** indexed_list_engine: FAILED **");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst                = 1'b1;
    command_valid      = 1'b0;
    command            = '0;
    position_in        = '0;
    word_in            = '0;
    error_count        = 0;
    idle_cycles        = 0;
    result_hold_cycles = 0;
    gaps_on            = 1'b1;
    list_count         = 0;
    foreach (list_words[i]) list_words[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_basic_commands();
    test_full_list();
    test_back_pressure();
    test_random_traffic(200, 1'b1);
    test_random_traffic(120, 1'b0);
    test_random_traffic(200, 1'b1);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("** indexed_list_engine: PASSED **");
    end else begin
      $display("** indexed_list_engine: FAILED **");
    end
    $finish;
  end

endmodule
